// ===== sv/rss_pkg.sv =====
`timescale 1ns / 1ps

package rss_pkg;

    localparam int MATRIX_ELEMS = 9;
    localparam int MAT_N        = 3;
    localparam int DIMENSIONS   = 4;
    localparam int SITES        = 256;

    localparam int DIRW  = 2;
    localparam int SITEW = 8;
    localparam int IDXW  = 4;
    localparam int RCW   = 2;
    localparam int NBAW  = DIRW + SITEW;
    localparam int LINK_DEPTH = DIMENSIONS * SITES * MATRIX_ELEMS;
    localparam int LAW   = $clog2(LINK_DEPTH);
    localparam int NB_DEPTH = DIMENSIONS * SITES;
    localparam int SCR_DEPTH = 2 * MATRIX_ELEMS;
    localparam int SCRW  = $clog2(SCR_DEPTH);

    // item kinds carried in s_tuser
    localparam logic [1:0] FN_LINK    = 2'd0;
    localparam logic [1:0] FN_NB      = 2'd1;
    localparam logic [1:0] FN_COMPUTE = 2'd2;

    // site selections for staple operands
    localparam logic [2:0] SS_X    = 3'd0;
    localparam logic [2:0] SS_XM   = 3'd1;
    localparam logic [2:0] SS_X2M  = 3'd2;
    localparam logic [2:0] SS_XMM  = 3'd3;
    localparam logic [2:0] SS_XN   = 3'd4;
    localparam logic [2:0] SS_XNM  = 3'd5;
    localparam logic [2:0] SS_XNMM = 3'd6;
    localparam logic [2:0] SS_X2N  = 3'd7;

    // operand slots of a five-link product
    localparam logic [2:0] SL_A = 3'd0;
    localparam logic [2:0] SL_B = 3'd1;
    localparam logic [2:0] SL_C = 3'd2;
    localparam logic [2:0] SL_D = 3'd3;
    localparam logic [2:0] SL_E = 3'd4;

    typedef struct packed {
        logic       use_nu;
        logic [2:0] site_sel;
        logic       dag;
    } src_t;

    typedef struct packed {
        logic            valid;
        logic            a_scr;
        logic            a_sel;
        logic [IDXW-1:0] a_idx;
        logic            a_dag;
        logic            b_dag;
        logic            first_k;
        logic            last_k;
        logic            dest_acc;
        logic            dest_sel;
        logic [IDXW-1:0] dest_idx;
    } issue_t;

    typedef struct packed {
        logic               valid;
        logic               dest_acc;
        logic               dest_sel;
        logic [IDXW-1:0]    dest_idx;
        logic signed [23:0] re;
        logic signed [23:0] im;
    } result_t;

    function automatic src_t staple_src(input logic [1:0] s, input logic [2:0] slot);
        src_t r;
        r = '{use_nu: 1'b0, site_sel: SS_X, dag: 1'b0};
        unique case ({s, slot})
            {2'd0, SL_A}: r = '{use_nu: 1'b1, site_sel: SS_X,    dag: 1'b0};
            {2'd0, SL_B}: r = '{use_nu: 1'b0, site_sel: SS_XN,   dag: 1'b0};
            {2'd0, SL_C}: r = '{use_nu: 1'b0, site_sel: SS_XNM,  dag: 1'b0};
            {2'd0, SL_D}: r = '{use_nu: 1'b1, site_sel: SS_X2M,  dag: 1'b1};
            {2'd0, SL_E}: r = '{use_nu: 1'b0, site_sel: SS_XM,   dag: 1'b1};
            {2'd1, SL_A}: r = '{use_nu: 1'b0, site_sel: SS_XMM,  dag: 1'b1};
            {2'd1, SL_B}: r = '{use_nu: 1'b1, site_sel: SS_XMM,  dag: 1'b0};
            {2'd1, SL_C}: r = '{use_nu: 1'b0, site_sel: SS_XNMM, dag: 1'b0};
            {2'd1, SL_D}: r = '{use_nu: 1'b0, site_sel: SS_XN,   dag: 1'b0};
            {2'd1, SL_E}: r = '{use_nu: 1'b1, site_sel: SS_XM,   dag: 1'b1};
            {2'd2, SL_A}: r = '{use_nu: 1'b1, site_sel: SS_X,    dag: 1'b0};
            {2'd2, SL_B}: r = '{use_nu: 1'b1, site_sel: SS_XN,   dag: 1'b0};
            {2'd2, SL_C}: r = '{use_nu: 1'b0, site_sel: SS_X2N,  dag: 1'b0};
            {2'd2, SL_D}: r = '{use_nu: 1'b1, site_sel: SS_XNM,  dag: 1'b1};
            {2'd2, SL_E}: r = '{use_nu: 1'b1, site_sel: SS_XM,   dag: 1'b1};
            default:      r = '{use_nu: 1'b0, site_sel: SS_X,    dag: 1'b0};
        endcase
        return r;
    endfunction

    function automatic logic [LAW-1:0] link_addr(input logic [DIRW-1:0] d,
                                                 input logic [SITEW-1:0] s,
                                                 input logic [IDXW-1:0] idx);
        logic [LAW-1:0] a;
        a = LAW'({d, s}) * LAW'(MATRIX_ELEMS) + LAW'(idx);
        return a;
    endfunction

    function automatic logic [IDXW-1:0] elem_idx(input logic [RCW-1:0] row,
                                                 input logic [RCW-1:0] col);
        return IDXW'(row) * IDXW'(MAT_N) + IDXW'(col);
    endfunction

endpackage

// ===== sv/rectangular_staple_sum_core.sv =====
`timescale 1ns / 1ps

// Rectangular 2x1 staple sum over a stored 3x3 complex gauge field (Q2.22 links,
// Q10.22 saturated sum). Link-element and neighbour-pair write items (s_tuser 0 and 1)
// go straight to the memories and return nothing. A compute item (s_tuser 2) returns
// nine items, element 0 first, tlast on element 8. All products run through one complex
// multiply-accumulate unit fed from the dual-read link memory. A compute item first
// looks up neighbour sites, then for each transverse direction looks up further
// neighbours and forms three staples of four products each, skipping the direction
// equal to its own, then sends out the nine sums.
// Only one item is in work at a time; s_tready is high while idle.
module rectangular_staple_sum_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // dir, site, elem, elem_re, elem_im, fwd_site, back_site, first_dir
    input  logic [79:0] s_tdata,
    // func
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_elem, sum_re, sum_im, zero pad
    output logic [71:0] m_tdata,
    output logic        m_tlast
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_LK_ISSUE = 3'd1;
    localparam logic [2:0] ST_LK_CAP   = 3'd2;
    localparam logic [2:0] ST_NU_CHECK = 3'd3;
    localparam logic [2:0] ST_MUL      = 3'd4;
    localparam logic [2:0] ST_DRAIN    = 3'd5;
    localparam logic [2:0] ST_OUT      = 3'd6;

    localparam int ME = rss_pkg::MATRIX_ELEMS;
    localparam logic [rss_pkg::RCW-1:0] RC_LAST = rss_pkg::RCW'(rss_pkg::MAT_N - 1);

    logic [2:0] state_reg, state_next;

    logic [1:0]  in_dir;
    logic [7:0]  in_site, in_fwd, in_back;
    logic [3:0]  in_elem;
    logic [23:0] in_re, in_im;
    logic [1:0]  in_first;
    logic        accept;

    logic [1:0] mu_reg, mu_next;
    logic [2:0] nu_reg, nu_next;
    logic [7:0] x_reg, x_next;
    logic [7:0] xm_reg, xm_next, x2m_reg, x2m_next, xmm_reg, xmm_next;
    logic [7:0] xn_reg, xn_next, xnm_reg, xnm_next, xnmm_reg, xnmm_next;
    logic [7:0] x2n_reg, x2n_next;
    logic [2:0] lk_reg, lk_next;
    logic [1:0] stp_reg, stp_next;
    logic [1:0] prod_reg, prod_next;
    logic [rss_pkg::RCW-1:0] r_reg, r_next, c_reg, c_next, k_reg, k_next;
    logic [3:0] oi_reg, oi_next;

    logic signed [31:0] sum_re [ME];
    logic signed [31:0] sum_im [ME];
    logic               sum_clear;

    logic        m_valid_reg, m_valid_next;
    logic [71:0] m_data_reg, m_data_next;
    logic        m_last_reg, m_last_next;

    logic                      lk_wr_en;
    logic [rss_pkg::LAW-1:0]   lk_wr_addr;
    logic [rss_pkg::LAW-1:0]   lk_addr_a, lk_addr_b;
    logic [47:0]               lk_data_a, lk_data_b;
    logic                      nb_wr_en;
    logic [rss_pkg::NBAW-1:0]  nb_addr;
    logic [15:0]               nb_data;

    rss_pkg::issue_t  issue;
    rss_pkg::result_t res;
    logic             mac_busy;

    rss_pkg::src_t src_a, src_b;
    logic [2:0]    slot_b;
    logic [1:0]    dir_a, dir_b;
    logic [7:0]    site_a, site_b;
    logic [3:0]    idx_a, idx_b;

    logic signed [32:0] acc_sum_re, acc_sum_im;

    function automatic logic [7:0] pick_site(input logic [2:0] sel,
        input logic [7:0] x, input logic [7:0] xm, input logic [7:0] x2m,
        input logic [7:0] xmm, input logic [7:0] xn, input logic [7:0] xnm,
        input logic [7:0] xnmm, input logic [7:0] x2n);
        logic [7:0] r;
        unique case (sel)
            rss_pkg::SS_X:    r = x;
            rss_pkg::SS_XM:   r = xm;
            rss_pkg::SS_X2M:  r = x2m;
            rss_pkg::SS_XMM:  r = xmm;
            rss_pkg::SS_XN:   r = xn;
            rss_pkg::SS_XNM:  r = xnm;
            rss_pkg::SS_XNMM: r = xnmm;
            rss_pkg::SS_X2N:  r = x2n;
            default:          r = x;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v > 33'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -33'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    assign in_dir   = s_tdata[1:0];
    assign in_site  = s_tdata[9:2];
    assign in_elem  = s_tdata[13:10];
    assign in_re    = s_tdata[37:14];
    assign in_im    = s_tdata[61:38];
    assign in_fwd   = s_tdata[69:62];
    assign in_back  = s_tdata[77:70];
    assign in_first = s_tdata[79:78];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // writes go straight to the memories
    assign lk_wr_en   = accept && (s_tuser == rss_pkg::FN_LINK)
                        && (in_elem < 4'(ME));
    assign lk_wr_addr = rss_pkg::link_addr(in_dir, in_site, in_elem);
    assign nb_wr_en   = accept && (s_tuser == rss_pkg::FN_NB);

    // neighbour lookup address by step
    always_comb begin
        unique case (lk_reg)
            3'd0:    nb_addr = {mu_reg, x_reg};
            3'd1:    nb_addr = {mu_reg, xm_reg};
            3'd2:    nb_addr = {nu_reg[1:0], x_reg};
            3'd3:    nb_addr = {mu_reg, xn_reg};
            default: nb_addr = {nu_reg[1:0], xn_reg};
        endcase
    end

    // operand selection for the current product
    always_comb begin
        unique case (prod_reg)
            2'd0:    slot_b = rss_pkg::SL_B;
            2'd1:    slot_b = rss_pkg::SL_C;
            2'd2:    slot_b = rss_pkg::SL_D;
            default: slot_b = rss_pkg::SL_E;
        endcase
        src_a  = rss_pkg::staple_src(stp_reg, rss_pkg::SL_A);
        src_b  = rss_pkg::staple_src(stp_reg, slot_b);
        dir_a  = src_a.use_nu ? nu_reg[1:0] : mu_reg;
        dir_b  = src_b.use_nu ? nu_reg[1:0] : mu_reg;
        site_a = pick_site(src_a.site_sel, x_reg, xm_reg, x2m_reg, xmm_reg,
                           xn_reg, xnm_reg, xnmm_reg, x2n_reg);
        site_b = pick_site(src_b.site_sel, x_reg, xm_reg, x2m_reg, xmm_reg,
                           xn_reg, xnm_reg, xnmm_reg, x2n_reg);
        idx_a  = (prod_reg == 2'd0 && src_a.dag) ? rss_pkg::elem_idx(k_reg, r_reg)
                                                 : rss_pkg::elem_idx(r_reg, k_reg);
        idx_b  = src_b.dag ? rss_pkg::elem_idx(c_reg, k_reg)
                           : rss_pkg::elem_idx(k_reg, c_reg);
        lk_addr_a = rss_pkg::link_addr(dir_a, site_a, idx_a);
        lk_addr_b = rss_pkg::link_addr(dir_b, site_b, idx_b);

        issue.valid    = (state_reg == ST_MUL);
        issue.a_scr    = (prod_reg != 2'd0);
        issue.a_sel    = (prod_reg == 2'd2);
        issue.a_idx    = idx_a;
        issue.a_dag    = (prod_reg == 2'd0) && src_a.dag;
        issue.b_dag    = src_b.dag;
        issue.first_k  = (k_reg == '0);
        issue.last_k   = (k_reg == RC_LAST);
        issue.dest_acc = (prod_reg == 2'd3);
        issue.dest_sel = (prod_reg == 2'd1);
        issue.dest_idx = rss_pkg::elem_idx(r_reg, c_reg);
    end

    rss_linkmem u_linkmem (
        .aclk      (aclk),
        .wr_en     (lk_wr_en),
        .wr_addr   (lk_wr_addr),
        .wr_data   ({in_re, in_im}),
        .rd_addr_a (lk_addr_a),
        .rd_addr_b (lk_addr_b),
        .rd_data_a (lk_data_a),
        .rd_data_b (lk_data_b)
    );

    rss_nbmem u_nbmem (
        .aclk    (aclk),
        .wr_en   (nb_wr_en),
        .wr_addr ({in_dir, in_site}),
        .wr_data ({in_fwd, in_back}),
        .rd_addr (nb_addr),
        .rd_data (nb_data)
    );

    rss_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .issue   (issue),
        .link_a  (lk_data_a),
        .link_b  (lk_data_b),
        .res     (res),
        .busy    (mac_busy)
    );

    always_comb begin
        state_next = state_reg;
        mu_next    = mu_reg;
        nu_next    = nu_reg;
        x_next     = x_reg;
        xm_next    = xm_reg;
        x2m_next   = x2m_reg;
        xmm_next   = xmm_reg;
        xn_next    = xn_reg;
        xnm_next   = xnm_reg;
        xnmm_next  = xnmm_reg;
        x2n_next   = x2n_reg;
        lk_next    = lk_reg;
        stp_next   = stp_reg;
        prod_next  = prod_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        k_next     = k_reg;
        oi_next    = oi_reg;
        sum_clear  = 1'b0;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_tuser == rss_pkg::FN_COMPUTE) begin
                    mu_next    = in_dir;
                    x_next     = in_site;
                    nu_next    = {1'b0, in_first};
                    lk_next    = 3'd0;
                    sum_clear  = 1'b1;
                    state_next = ST_LK_ISSUE;
                end
            end
            ST_LK_ISSUE: begin
                state_next = ST_LK_CAP;
            end
            ST_LK_CAP: begin
                unique case (lk_reg)
                    3'd0: begin
                        xm_next  = nb_data[15:8];
                        xmm_next = nb_data[7:0];
                    end
                    3'd1: x2m_next = nb_data[15:8];
                    3'd2: xn_next  = nb_data[15:8];
                    3'd3: begin
                        xnm_next  = nb_data[15:8];
                        xnmm_next = nb_data[7:0];
                    end
                    default: x2n_next = nb_data[15:8];
                endcase
                lk_next = lk_reg + 3'd1;
                if (lk_reg == 3'd1) begin
                    state_next = ST_NU_CHECK;
                end else if (lk_reg == 3'd4) begin
                    stp_next   = 2'd0;
                    prod_next  = 2'd0;
                    r_next     = '0;
                    c_next     = '0;
                    k_next     = '0;
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_LK_ISSUE;
                end
            end
            ST_NU_CHECK: begin
                if (nu_reg >= 3'(rss_pkg::DIMENSIONS)) begin
                    oi_next    = 4'd0;
                    state_next = ST_OUT;
                end else if (nu_reg[1:0] == mu_reg) begin
                    nu_next = nu_reg + 3'd1;
                end else begin
                    lk_next    = 3'd2;
                    state_next = ST_LK_ISSUE;
                end
            end
            ST_MUL: begin
                if (k_reg != RC_LAST) begin
                    k_next = k_reg + 1'b1;
                end else begin
                    k_next = '0;
                    if (c_reg != RC_LAST) begin
                        c_next = c_reg + 1'b1;
                    end else begin
                        c_next = '0;
                        if (r_reg != RC_LAST) begin
                            r_next = r_reg + 1'b1;
                        end else begin
                            r_next     = '0;
                            state_next = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN: begin
                // next product reads what this one wrote to scratch
                if (!mac_busy) begin
                    if (prod_reg != 2'd3) begin
                        prod_next  = prod_reg + 2'd1;
                        state_next = ST_MUL;
                    end else if (stp_reg != 2'd2) begin
                        prod_next  = 2'd0;
                        stp_next   = stp_reg + 2'd1;
                        state_next = ST_MUL;
                    end else begin
                        nu_next    = nu_reg + 3'd1;
                        state_next = ST_NU_CHECK;
                    end
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {4'd0, sum_im[oi_reg], sum_re[oi_reg], oi_reg};
                    m_last_next  = (oi_reg == 4'(ME - 1));
                    oi_next      = oi_reg + 4'd1;
                    if (oi_reg == 4'(ME - 1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign acc_sum_re = {sum_re[res.dest_idx][31], sum_re[res.dest_idx]}
                        + {{9{res.re[23]}}, res.re};
    assign acc_sum_im = {sum_im[res.dest_idx][31], sum_im[res.dest_idx]}
                        + {{9{res.im[23]}}, res.im};

    always_ff @(posedge aclk) begin
        if (sum_clear) begin
            for (int i = 0; i < ME; i++) begin
                sum_re[i] <= '0;
                sum_im[i] <= '0;
            end
        end else if (res.valid && res.dest_acc) begin
            sum_re[res.dest_idx] <= sat32(acc_sum_re);
            sum_im[res.dest_idx] <= sat32(acc_sum_im);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            lk_reg      <= '0;
            stp_reg     <= '0;
            prod_reg    <= '0;
            r_reg       <= '0;
            c_reg       <= '0;
            k_reg       <= '0;
            oi_reg      <= '0;
            nu_reg      <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            lk_reg      <= lk_next;
            stp_reg     <= stp_next;
            prod_reg    <= prod_next;
            r_reg       <= r_next;
            c_reg       <= c_next;
            k_reg       <= k_next;
            oi_reg      <= oi_next;
            nu_reg      <= nu_next;
        end
    end

    always_ff @(posedge aclk) begin
        mu_reg     <= mu_next;
        x_reg      <= x_next;
        xm_reg     <= xm_next;
        x2m_reg    <= x2m_next;
        xmm_reg    <= xmm_next;
        xn_reg     <= xn_next;
        xnm_reg    <= xnm_next;
        xnmm_reg   <= xnmm_next;
        x2n_reg    <= x2n_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== sv/rss_linkmem.sv =====
`timescale 1ns / 1ps

module rss_linkmem (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [rss_pkg::LAW-1:0]   wr_addr,
    input  logic [47:0]               wr_data,
    input  logic [rss_pkg::LAW-1:0]   rd_addr_a,
    input  logic [rss_pkg::LAW-1:0]   rd_addr_b,
    output logic [47:0]               rd_data_a,
    output logic [47:0]               rd_data_b
);

    logic [47:0] mem [rss_pkg::LINK_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ===== sv/rss_nbmem.sv =====
`timescale 1ns / 1ps

module rss_nbmem (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [rss_pkg::NBAW-1:0]   wr_addr,
    input  logic [15:0]                wr_data,
    input  logic [rss_pkg::NBAW-1:0]   rd_addr,
    output logic [15:0]                rd_data
);

    // forward site in the upper byte, backward site in the lower byte
    logic [15:0] mem [rss_pkg::NB_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== sv/rss_mac.sv =====
`timescale 1ns / 1ps

module rss_mac (
    input  logic                aclk,
    input  logic                aresetn,
    input  rss_pkg::issue_t     issue,
    input  logic [47:0]         link_a,
    input  logic [47:0]         link_b,
    output rss_pkg::result_t    res,
    output logic                busy
);

    logic [47:0] scr [rss_pkg::SCR_DEPTH];
    logic [47:0] scr_rd_reg;
    logic [rss_pkg::SCRW-1:0] scr_raddr;
    logic [rss_pkg::SCRW-1:0] scr_waddr;

    rss_pkg::issue_t ctl1_reg, ctl2_reg, ctl3_reg;
    rss_pkg::result_t res_reg, res_next;

    logic [47:0] op_a;
    logic signed [24:0] ar, ai, br, bi;
    logic signed [49:0] prr_reg, pii_reg, pri_reg, pir_reg;
    logic signed [50:0] term_re, term_im;
    logic signed [52:0] acc_re_reg, acc_im_reg, acc_re_next, acc_im_next;
    logic signed [52:0] rnd_re, rnd_im;

    function automatic logic signed [23:0] round_sat(input logic signed [52:0] v);
        logic signed [52:0] t;
        logic signed [23:0] r;
        t = (v + 53'sd2097152) >>> 22;
        if (t > 53'sd8388607) begin
            r = 24'sh7fffff;
        end else if (t < -53'sd8388608) begin
            r = -24'sd8388608;
        end else begin
            r = t[23:0];
        end
        return r;
    endfunction

    assign scr_raddr = rss_pkg::SCRW'(issue.a_sel) * rss_pkg::SCRW'(rss_pkg::MATRIX_ELEMS)
                     + rss_pkg::SCRW'(issue.a_idx);
    assign scr_waddr = rss_pkg::SCRW'(res_reg.dest_sel) * rss_pkg::SCRW'(rss_pkg::MATRIX_ELEMS)
                     + rss_pkg::SCRW'(res_reg.dest_idx);

    always_ff @(posedge aclk) begin
        scr_rd_reg <= scr[scr_raddr];
        if (res_reg.valid && !res_reg.dest_acc) begin
            scr[scr_waddr] <= {res_reg.re, res_reg.im};
        end
    end

    // operand fetch and complex multiply
    always_comb begin
        op_a = ctl1_reg.a_scr ? scr_rd_reg : link_a;
        ar = {op_a[47], op_a[47:24]};
        ai = ctl1_reg.a_dag ? -{op_a[23], op_a[23:0]} : {op_a[23], op_a[23:0]};
        br = {link_b[47], link_b[47:24]};
        bi = ctl1_reg.b_dag ? -{link_b[23], link_b[23:0]} : {link_b[23], link_b[23:0]};
    end

    always_ff @(posedge aclk) begin
        prr_reg <= ar * br;
        pii_reg <= ai * bi;
        pri_reg <= ar * bi;
        pir_reg <= ai * br;
    end

    // accumulate over the inner index
    always_comb begin
        term_re = {prr_reg[49], prr_reg} - {pii_reg[49], pii_reg};
        term_im = {pri_reg[49], pri_reg} + {pir_reg[49], pir_reg};
        if (ctl2_reg.first_k) begin
            acc_re_next = {{2{term_re[50]}}, term_re};
            acc_im_next = {{2{term_im[50]}}, term_im};
        end else begin
            acc_re_next = acc_re_reg + {{2{term_re[50]}}, term_re};
            acc_im_next = acc_im_reg + {{2{term_im[50]}}, term_im};
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl2_reg.valid) begin
            acc_re_reg <= acc_re_next;
            acc_im_reg <= acc_im_next;
        end
    end

    always_comb begin
        rnd_re = acc_re_reg;
        rnd_im = acc_im_reg;
        res_next.valid    = ctl3_reg.valid && ctl3_reg.last_k;
        res_next.dest_acc = ctl3_reg.dest_acc;
        res_next.dest_sel = ctl3_reg.dest_sel;
        res_next.dest_idx = ctl3_reg.dest_idx;
        res_next.re       = round_sat(rnd_re);
        res_next.im       = round_sat(rnd_im);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            res_reg  <= '0;
        end else begin
            ctl1_reg <= issue;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            res_reg  <= res_next;
        end
    end

    assign res  = res_reg;
    assign busy = ctl1_reg.valid | ctl2_reg.valid | ctl3_reg.valid | res_reg.valid;

endmodule

// ===== sv/rss_checker.sv =====
`timescale 1ns / 1ps

module rss_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic        m_tlast
);

    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // write items finish in the cycle they are taken
    a_write_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser != rss_pkg::FN_COMPUTE |=> s_tready)
        else $error("write item stalled the input");

    a_compute_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == rss_pkg::FN_COMPUTE |=> !s_tready)
        else $error("compute item did not hold off input");

endmodule

bind rectangular_staple_sum_core rss_checker u_rss_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
